[design/kls_pkg.sv]
package kls_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // control shared by every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    // one stored entry as handed between neighbors
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

endpackage

[design/keyed_list_store_unit.sv]
// keyed list store: up to CAPACITY entries of 32-bit key and 64-bit payload,
// newest at the head, kept in a chain of cells that shift toward or away
// from the head.
// command channel: a beat is taken at a clock edge with i_start high and
// o_busy low; it carries i_cmd (insert, lookup, remove), i_key and
// i_payload_in.
// result channel: o_done is high for exactly one cycle per command beat and
// marks o_status, o_payload_out and o_entry_count for that cycle.
// each accepted command passes through the command register and then the
// result register, which drives o_done and the result outputs.
// a command is first registered; the compare and shift then run in every cell
// at once and load the result register. o_busy is high while they run, so no
// new command is taken before the last one has been through the chain.
// every cell compares its key in parallel; the first hit from the head wins.
// reset (i_rst_n low, synchronous) empties the list and drops any command in
// flight; stored cell contents are not cleared, only the entry count.
// the receiver cannot stall: each result beat is presented once and is gone.
module keyed_list_store_unit import kls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [1:0]       i_cmd,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload_in,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [PAY_W-1:0] o_payload_out,
    output logic [4:0]       o_entry_count
);

    // command register, loaded on the accepted beat
    logic             r_pend;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;

    // list state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic             r_done;
    t_status          r_status;
    t_status          n_status;
    logic [PAY_W-1:0] r_payout;
    logic [PAY_W-1:0] n_payout;

    t_cell_ctl        ctl;
    t_entry           head_in;
    t_entry           tail_in;
    t_entry           cell_q   [CAPACITY];
    logic             hit      [CAPACITY+1];
    logic             sel      [CAPACITY];
    logic [PAY_W-1:0] sel_pay  [CAPACITY];
    logic             found;
    logic             full;
    logic             accept;

    assign accept = i_start & ~r_pend;
    assign o_busy = r_pend;
    assign full   = (r_count >= CNT_W'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= accept;
        end
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_pay <= i_payload_in;
        end
    end

    // shared control for the chain, only while a command is in flight
    always_comb begin
        ctl.key = r_key;
        ctl.ins = 1'b0;
        ctl.rem = 1'b0;
        if (r_pend) begin
            unique case (t_cmd'(r_cmd))
                CMD_INSERT: ctl.ins = ~full;
                CMD_REMOVE: ctl.rem = 1'b1;
                CMD_LOOKUP,
                CMD_NONE:   ctl.ins = 1'b0;
                default:    ctl.ins = 1'b0;
            endcase
        end
    end

    assign head_in.key     = r_key;
    assign head_in.payload = r_pay;
    assign tail_in         = '0;
    assign hit[0]          = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry prev_e;
            t_entry next_e;
            logic   occ;

            assign occ    = (CNT_W'(gi) < r_count);
            assign prev_e = (gi == 0) ? head_in : cell_q[(gi == 0) ? 0 : gi - 1];
            assign next_e = (gi == CAPACITY - 1) ? tail_in
                          : cell_q[(gi == CAPACITY - 1) ? gi : gi + 1];

            kls_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ),
                .i_hit_before (hit[gi]),
                .i_prev       (prev_e),
                .i_next       (next_e),
                .o_entry      (cell_q[gi]),
                .o_hit        (hit[gi+1]),
                .o_sel        (sel[gi])
            );

            // at most one cell is selected, so an or of masked payloads is the mux
            assign sel_pay[gi] = sel[gi] ? cell_q[gi].payload : '0;
        end
    endgenerate

    assign found = hit[CAPACITY];

    always_comb begin
        n_payout = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            n_payout = n_payout | sel_pay[k];
        end
    end

    // status, result payload and new entry count
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        unique case (t_cmd'(r_cmd))
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_LOOKUP: begin
                if (!found) begin
                    n_status = ST_ABSENT;
                end
            end
            CMD_REMOVE: begin
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            CMD_NONE: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_pend;
            if (r_pend) begin
                r_count <= n_count;
            end
        end
        if (r_pend) begin
            r_status <= n_status;
            r_payout <= (t_cmd'(r_cmd) == CMD_LOOKUP) ? n_payout : '0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_payload_out = r_payout;
    assign o_entry_count = 5'(r_count);

endmodule

[design/kls_cell.sv]
module kls_cell import kls_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_hit_before,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_hit,
    output logic      o_sel
);

    t_entry r_entry;
    t_entry n_entry;
    logic   match;

    assign match   = i_occ && (r_entry.key == i_ctl.key);
    assign o_hit   = i_hit_before | match;
    assign o_sel   = match & ~i_hit_before;
    assign o_entry = r_entry;

    // insert pulls from the head side, remove pulls from the tail side at and past the hit
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            n_entry = i_prev;
        end else if (i_ctl.rem && o_hit) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[tb/kls_list_checker.sv]
`timescale 1ns / 1ps

module kls_list_checker import kls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             o_busy,
    input  logic [1:0]       i_cmd,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload_in,
    input  logic             o_done,
    input  logic [1:0]       o_status,
    input  logic [PAY_W-1:0] o_payload_out,
    input  logic [4:0]       o_entry_count,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        t_status          status;
        logic [PAY_W-1:0] payload;
        logic [4:0]       count;
    } t_list_result;

    // shadow copy of the list, head at index 0
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [PAY_W-1:0] shadow_pays [CAPACITY];
    int               shadow_count;

    t_list_result     pending_results [$];
    t_list_result     oldest_result;

    // applies one command to the shadow list and returns its result beat
    function automatic t_list_result apply_list_command(t_cmd cmd, logic [KEY_W-1:0] key,
                                                        logic [PAY_W-1:0] pay);
        t_list_result r;
        int           hit;
        r.status  = ST_OK;
        r.payload = '0;
        hit       = -1;
        // scan from the tail so the match nearest the head wins
        for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_keys[i] == key)
                hit = i;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_count; i > 0; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_pays[i] = shadow_pays[i-1];
                    end
                    shadow_keys[0] = key;
                    shadow_pays[0] = pay;
                    shadow_count++;
                end
            end
            CMD_LOOKUP: begin
                if (hit < 0)
                    r.status = ST_ABSENT;
                else
                    r.payload = shadow_pays[hit];
            end
            CMD_REMOVE: begin
                if (hit < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    for (int i = hit; i < shadow_count - 1; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_pays[i] = shadow_pays[i+1];
                    end
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.count = 5'(shadow_count);
        return r;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        shadow_count  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            pending_results.delete();
        end else begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (o_status !== oldest_result.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest_result.status, o_status);
                        fail_count++;
                    end
                    if (o_payload_out !== oldest_result.payload) begin
                        $error("payload_out: expected %h, actual %h",
                               oldest_result.payload, o_payload_out);
                        fail_count++;
                    end
                    if (o_entry_count !== oldest_result.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest_result.count, o_entry_count);
                        fail_count++;
                    end
                end
            end
            if (i_start && !o_busy)
                pending_results.push_back(apply_list_command(t_cmd'(i_cmd), i_key,
                                                             i_payload_in));
        end
        pending_count = pending_results.size();
    end

endmodule

[tb/tb_keyed_list_store_unit.sv]
`timescale 1ns / 1ps

module tb_keyed_list_store_unit;
    import kls_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic [1:0]       i_cmd;
    logic [KEY_W-1:0] i_key;
    logic [PAY_W-1:0] i_payload_in;
    logic             o_done;
    logic [1:0]       o_status;
    logic [PAY_W-1:0] o_payload_out;
    logic [4:0]       o_entry_count;

    int               fail_count;
    int               pending_count;

    // set at the edge that takes a command beat, read back at the next falling edge
    logic             cmd_taken;
    // while set, the sender puts commands back to back with no gap
    logic             burst_mode;

    keyed_list_store_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_payload_in  (i_payload_in),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count)
    );

    // shadow list, prediction and result comparison live in the checker
    kls_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_payload_in  (i_payload_in),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && i_start && !o_busy;
    end

    // hard stop in case the block hangs or drops a result
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // present one command beat from a falling edge and hold it until taken,
    // then idle for a random number of cycles unless in burst mode
    task automatic send_command(t_cmd cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        int gap;
        i_start      <= 1'b1;
        i_cmd        <= cmd;
        i_key        <= key;
        i_payload_in <= pay;
        do
            @(negedge i_clk);
        while (!cmd_taken);
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        // start stays high for a zero gap so it is never dropped and raised in one step
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // hold the sender off until every result beat has come back
    task automatic wait_for_drain();
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0] key_pool [8];
        int               sent_items;
        int               mode;
        int               insert_pct;
        int               lookup_pct;
        int               roll;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;

        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = CMD_NONE;
        i_key        = '0;
        i_payload_in = '0;
        burst_mode   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-list misses, key and payload extremes, duplicate keys
        send_command(CMD_LOOKUP, 32'h0000_0000, '0);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, '1);
        send_command(CMD_INSERT, 32'h0000_0000, 64'h0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000, 64'hA5A5_5A5A_0F0F_F0F0);
        // the newer duplicate of key zero must answer
        send_command(CMD_LOOKUP, 32'h0000_0000, '0);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
        send_command(CMD_REMOVE, 32'h0000_0000, '0);
        // now the older duplicate shows through
        send_command(CMD_LOOKUP, 32'h0000_0000, '0);
        // unused command code leaves the list alone
        send_command(CMD_NONE, 32'hFFFF_FFFF, '1);
        // fill to capacity, then one insert too many
        for (int i = 0; i < CAPACITY - 2; i++)
            send_command(CMD_INSERT, 32'h100 + i, {$urandom(), $urandom()});
        send_command(CMD_INSERT, 32'h5555_AAAA, '1);
        // drop the entry at the tail, then look for it again
        send_command(CMD_REMOVE, 32'h0000_0000, '0);
        send_command(CMD_LOOKUP, 32'h0000_0000, '0);

        i_start <= 1'b0;
        wait_for_drain();
        @(negedge i_clk);

        // random: blocks of 100 commands, each with its own mix and key pool so
        // the list fills, drains and sees plenty of hits and duplicates
        sent_items = 0;
        mode       = 0;
        insert_pct = 0;
        lookup_pct = 0;
        while (sent_items < 1350) begin
            if (sent_items % 100 == 0) begin
                mode       = $urandom_range(0, 2);
                burst_mode = ($urandom_range(0, 3) == 0);
                case (mode)
                    0:       begin insert_pct = 60; lookup_pct = 25; end // fill up
                    1:       begin insert_pct = 20; lookup_pct = 30; end // drain
                    default: begin insert_pct = 35; lookup_pct = 35; end
                endcase
                foreach (key_pool[i])
                    key_pool[i] = $urandom();
                key_pool[7] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                // now and then let everything settle before going on
                if (sent_items % 300 == 0) begin
                    i_start <= 1'b0;
                    wait_for_drain();
                    @(negedge i_clk);
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_NONE;
            else if (roll < 3 + insert_pct)
                cmd = CMD_INSERT;
            else if (roll < 3 + insert_pct + lookup_pct)
                cmd = CMD_LOOKUP;
            else
                cmd = CMD_REMOVE;
            // mostly pool keys for hits and duplicates, some fully random
            key = ($urandom_range(0, 6) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
            send_command(cmd, key, {$urandom(), $urandom()});
            if (cmd != CMD_NONE)
                sent_items++;
        end

        i_start <= 1'b0;
        wait_for_drain();
        repeat (6) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
design/kls_pkg.sv
design/kls_cell.sv
design/keyed_list_store_unit.sv
tb/kls_list_checker.sv
tb/tb_keyed_list_store_unit.sv
